// ===== design/trwp_pkg.sv =====
package trwp_pkg;

  localparam int unsigned EventDepthDefault = 8192;
  localparam int unsigned MaxWritesDefault  = 63;

  localparam int unsigned CountW    = 14;
  localparam int unsigned PtrW      = CountW;
  localparam int unsigned TickW     = 16;
  localparam int unsigned IncrW     = 16;
  localparam int unsigned LoadIdxW  = 13;
  localparam int unsigned RegW      = 8;
  localparam int unsigned ValW      = 8;
  localparam int unsigned WrCntW    = 6;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned PhaseWrap = 32'h0001_0000;

  localparam logic OpTick = 1'b0;
  localparam logic OpLoad = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgEventCount    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTickIncrement = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [LoadIdxW-1:0] load_index;
    logic [TickW-1:0]    load_tick;
    logic [RegW-1:0]     load_register;
    logic [ValW-1:0]     load_data;
  } trwp_in_t;

  typedef struct packed {
    logic            is_write;
    logic [RegW-1:0] reg_address;
    logic [ValW-1:0] reg_value;
    logic            chain_pulse;
    logic            overflow;
    logic            last;
  } trwp_out_t;

  typedef struct packed {
    logic [TickW-1:0] tick;
    logic [RegW-1:0]  register;
    logic [ValW-1:0]  data;
  } trwp_event_t;

  typedef struct packed {
    logic we;
    logic re;
  } trwp_mem_ctl_t;

endpackage

// ===== design/timed_register_write_player_top.sv =====
// channel | direction | handshake            | payload
// cfg     | in        | cfg_we_i             | cfg_index_i, cfg_data_i
// in      | in        | in_valid_i/in_stall_o | in_data_i (trwp_in_t)
// out     | out       | out_valid_o/out_stall_i | out_data_o (trwp_out_t)
//
// A load beat writes the event store. During a tick, each event costs one
// event store read plus one compare, skipped events included.
// Every beat of output leaves through one output register; a stall on it
// holds the sequencer only when a new beat is due.
// Reset clears the pointer, tick index, accumulator and config; the event
// store has no reset and needs no clearing pass.
module timed_register_write_player_top #(
  parameter int unsigned EVENT_DEPTH         = trwp_pkg::EventDepthDefault,
  parameter int unsigned MAX_WRITES_PER_TICK = trwp_pkg::MaxWritesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [trwp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [trwp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  trwp_pkg::trwp_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output trwp_pkg::trwp_out_t           out_data_o
);

  localparam int unsigned AddrW = $clog2(EVENT_DEPTH);

  trwp_pkg::trwp_mem_ctl_t mem_ctl;
  logic [AddrW-1:0]        mem_addr;
  trwp_pkg::trwp_event_t   mem_wdata;
  trwp_pkg::trwp_event_t   mem_rdata;

  trwp_ctrl #(
    .EventDepth (EVENT_DEPTH),
    .MaxWrites  (MAX_WRITES_PER_TICK),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  trwp_mem #(
    .Depth (EVENT_DEPTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== design/trwp_mem.sv =====
module trwp_mem #(
  parameter int unsigned Depth = trwp_pkg::EventDepthDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  trwp_pkg::trwp_mem_ctl_t ctl_i,
  input  logic [AddrW-1:0]      addr_i,
  input  trwp_pkg::trwp_event_t wdata_i,
  output trwp_pkg::trwp_event_t rdata_o
);

  trwp_pkg::trwp_event_t mem [Depth];
  trwp_pkg::trwp_event_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/trwp_ctrl.sv =====
module trwp_ctrl #(
  parameter int unsigned EventDepth = trwp_pkg::EventDepthDefault,
  parameter int unsigned MaxWrites  = trwp_pkg::MaxWritesDefault,
  parameter int unsigned AddrW      = $clog2(EventDepth)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [trwp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [trwp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  trwp_pkg::trwp_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output trwp_pkg::trwp_out_t          out_data_o,
  output trwp_pkg::trwp_mem_ctl_t      mem_ctl_o,
  output logic [AddrW-1:0]             mem_addr_o,
  output trwp_pkg::trwp_event_t        mem_wdata_o,
  input  trwp_pkg::trwp_event_t        mem_rdata_i
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StIssue  = 2'd1;
  localparam logic [1:0] StEval   = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  localparam logic [trwp_pkg::WrCntW-1:0] MaxWr = trwp_pkg::WrCntW'(MaxWrites);

  logic [1:0]                    state_q, state_d;
  logic [trwp_pkg::PtrW-1:0]     ptr_q, ptr_d;
  logic [trwp_pkg::TickW-1:0]    tick_idx_q, tick_idx_d;
  logic [trwp_pkg::IncrW-1:0]    acc_q, acc_d;
  logic [trwp_pkg::WrCntW-1:0]   nwr_q, nwr_d;
  logic                          ovf_q, ovf_d;
  logic [trwp_pkg::CountW-1:0]   count_q;
  logic [trwp_pkg::IncrW-1:0]    incr_q;
  logic                          out_valid_q, out_valid_d;
  trwp_pkg::trwp_out_t           out_q, out_d;

  logic [trwp_pkg::CountW-1:0]   cnt_cap;
  logic                          out_free;
  logic                          in_acc;
  logic                          ptr_in_list;
  logic [trwp_pkg::IncrW:0]      phase_sum;
  logic                          chain;

  // count beyond the store acts as the store depth
  assign cnt_cap = (32'(count_q) > EventDepth) ? trwp_pkg::CountW'(EventDepth) : count_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign ptr_in_list = (ptr_q < cnt_cap);
  assign phase_sum   = {1'b0, acc_q} + {1'b0, incr_q};
  assign chain       = (32'(phase_sum) >= trwp_pkg::PhaseWrap);

  assign mem_wdata_o = '{tick:     in_data_i.load_tick,
                         register: in_data_i.load_register,
                         data:     in_data_i.load_data};

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    tick_idx_d  = tick_idx_q;
    acc_d       = acc_q;
    nwr_d       = nwr_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_ctl_o   = '0;
    mem_addr_o  = AddrW'(ptr_q);

    unique case (state_q)
      StIdle: begin
        mem_addr_o = AddrW'(in_data_i.load_index);
        if (in_acc) begin
          if (in_data_i.operation == trwp_pkg::OpLoad) begin
            mem_ctl_o.we = (32'(in_data_i.load_index) < EventDepth);
          end else begin
            nwr_d   = '0;
            ovf_d   = 1'b0;
            state_d = StIssue;
          end
        end
      end
      StIssue: begin
        if (ptr_in_list) begin
          mem_ctl_o.re = 1'b1;
          state_d      = StEval;
        end else begin
          state_d = StFinish;
        end
      end
      StEval: begin
        if (mem_rdata_i.tick == tick_idx_q) begin
          if (nwr_q < MaxWr) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_d       = '{is_write: 1'b1, reg_address: mem_rdata_i.register,
                              reg_value: mem_rdata_i.data, chain_pulse: 1'b0,
                              overflow: 1'b0, last: 1'b0};
              nwr_d       = nwr_q + 1'b1;
              ptr_d       = ptr_q + 1'b1;
              state_d     = StIssue;
            end
          end else begin
            // past the per-tick limit: skip the event
            ovf_d   = 1'b1;
            ptr_d   = ptr_q + 1'b1;
            state_d = StIssue;
          end
        end else begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{is_write: 1'b0, reg_address: '0, reg_value: '0,
                          chain_pulse: chain, overflow: ovf_q, last: 1'b1};
          acc_d       = phase_sum[trwp_pkg::IncrW-1:0];
          if (!ptr_in_list) begin
            ptr_d      = '0;
            tick_idx_d = '0;
          end else begin
            tick_idx_d = tick_idx_q + 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ptr_q       <= '0;
      tick_idx_q  <= '0;
      acc_q       <= '0;
      nwr_q       <= '0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      incr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      tick_idx_q  <= tick_idx_d;
      acc_q       <= acc_d;
      nwr_q       <= nwr_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          trwp_pkg::CfgEventCount:    count_q <= cfg_data_i[trwp_pkg::CountW-1:0];
          trwp_pkg::CfgTickIncrement: incr_q  <= cfg_data_i[trwp_pkg::IncrW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_mem_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl_o.we && mem_ctl_o.re))
    else $error("event store read and write in the same cycle");

  a_eval_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEval) |-> ($past(state_q) == StIssue || $past(state_q) == StEval))
    else $error("evaluate without a preceding read");

  a_wr_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nwr_q <= MaxWr)
    else $error("write count beyond per-tick limit");

  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish && out_free) |=> (state_q == StIdle && out_valid_q && out_q.last))
    else $error("status beat not issued at tick end");

endmodule

// ===== bench/tb_timed_register_write_player_top.sv =====
module tb_timed_register_write_player_top;

  localparam int unsigned Depth        = trwp_pkg::EventDepthDefault;
  localparam int unsigned MaxWrites    = trwp_pkg::MaxWritesDefault;
  localparam int unsigned CountMax     = (1 << trwp_pkg::CountW) - 1;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles  = 200;
  localparam int unsigned RandomItems  = 80;

  // Tracks the event list, pointer, tick index and phase, and holds the beats
  // the block still owes.
  class playback_tracker;
    trwp_pkg::trwp_event_t       events [Depth];
    bit                          loaded [Depth];
    trwp_pkg::trwp_out_t         due_beats [$];
    logic [trwp_pkg::CountW-1:0] event_count;
    logic [trwp_pkg::IncrW-1:0]  tick_incr;
    logic [trwp_pkg::TickW-1:0]  tick_idx;
    logic [16:0]                 phase_acc;
    int unsigned                 play_ptr;
    int unsigned                 errors;

    function new();
      event_count = '0;
      tick_incr   = '0;
      tick_idx    = '0;
      phase_acc   = '0;
      play_ptr    = 0;
      errors      = 0;
    endfunction

    function int unsigned active_len();
      return (event_count > Depth) ? Depth : int'(event_count);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // First list entry the next tick would read without it being loaded.
    function int unread_hole();
      int unsigned p;
      p = play_ptr;
      while (p < active_len()) begin
        if (!loaded[p]) return int'(p);
        if (events[p].tick != tick_idx) return -1;
        p++;
      end
      return -1;
    endfunction

    function void apply_input(trwp_pkg::trwp_in_t beat);
      trwp_pkg::trwp_out_t res;
      int unsigned         lim;
      int unsigned         n;
      logic                ovf;
      logic [16:0]         sum;
      if (beat.operation == trwp_pkg::OpLoad) begin
        events[beat.load_index] = {beat.load_tick, beat.load_register, beat.load_data};
        loaded[beat.load_index] = 1'b1;
        return;
      end
      lim = active_len();
      n   = 0;
      ovf = 1'b0;
      while (play_ptr < lim && events[play_ptr].tick == tick_idx) begin
        if (n < MaxWrites) begin
          res             = '0;
          res.is_write    = 1'b1;
          res.reg_address = events[play_ptr].register;
          res.reg_value   = events[play_ptr].data;
          due_beats.push_back(res);
          n++;
        end else begin
          ovf = 1'b1;
        end
        play_ptr++;
      end
      sum       = phase_acc + tick_incr;
      phase_acc = {1'b0, sum[15:0]};
      if (play_ptr >= lim) begin
        play_ptr = 0;
        tick_idx = '0;
      end else begin
        tick_idx = tick_idx + 1'b1;
      end
      res             = '0;
      res.chain_pulse = sum[16];
      res.overflow    = ovf;
      res.last        = 1'b1;
      due_beats.push_back(res);
    endfunction

    task match_output(trwp_pkg::trwp_out_t got);
      trwp_pkg::trwp_out_t want;
      if (due_beats.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
        return;
      end
      want = due_beats.pop_front();
      if (got.is_write !== want.is_write)
        report($sformatf("is_write got %b exp %b", got.is_write, want.is_write));
      if (got.reg_address !== want.reg_address)
        report($sformatf("reg_address got %h exp %h", got.reg_address, want.reg_address));
      if (got.reg_value !== want.reg_value)
        report($sformatf("reg_value got %h exp %h", got.reg_value, want.reg_value));
      if (got.chain_pulse !== want.chain_pulse)
        report($sformatf("chain_pulse got %b exp %b", got.chain_pulse, want.chain_pulse));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow got %b exp %b", got.overflow, want.overflow));
      if (got.last !== want.last)
        report($sformatf("last got %b exp %b", got.last, want.last));
    endtask
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [trwp_pkg::CfgIdxW-1:0]  cfg_index_i = trwp_pkg::CfgEventCount;
  logic [trwp_pkg::CfgDataW-1:0] cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  trwp_pkg::trwp_in_t            in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  trwp_pkg::trwp_out_t           out_data_o;

  playback_tracker tracker = new();
  int unsigned     gap_pct   = 0;
  int unsigned     stall_pct = 0;
  int unsigned     items_sent = 0;
  int unsigned     cycles = 0;

  timed_register_write_player_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.match_output(out_data_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic trwp_pkg::trwp_in_t make_load(int unsigned idx, int unsigned tick,
                                                   int unsigned addr, int unsigned val);
    trwp_pkg::trwp_in_t beat;
    beat.operation     = trwp_pkg::OpLoad;
    beat.load_index    = trwp_pkg::LoadIdxW'(idx);
    beat.load_tick     = trwp_pkg::TickW'(tick);
    beat.load_register = trwp_pkg::RegW'(addr);
    beat.load_data     = trwp_pkg::ValW'(val);
    return beat;
  endfunction

  function automatic trwp_pkg::trwp_in_t make_tick();
    logic [63:0]        noise;
    trwp_pkg::trwp_in_t beat;
    noise          = {$urandom(), $urandom()};
    beat           = noise[$bits(trwp_pkg::trwp_in_t)-1:0];
    beat.operation = trwp_pkg::OpTick;
    return beat;
  endfunction

  function automatic int unsigned pick_incr();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 46; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 46; end
      default: begin gap_pct = 29; stall_pct = 29; end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(trwp_pkg::trwp_in_t beat);
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.apply_input(beat);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Never let a tick read a list entry that was not loaded.
  task automatic send_tick();
    int hole;
    hole = tracker.unread_hole();
    while (hole >= 0) begin
      send_item(make_load(hole, $urandom_range(0, 16'hFFFF), $urandom_range(0, 255),
                          $urandom_range(0, 255)));
      hole = tracker.unread_hole();
    end
    send_item(make_tick());
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.due_beats.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_cfg(int unsigned cnt, int unsigned inc);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= trwp_pkg::CfgEventCount;
    cfg_data_i  <= trwp_pkg::CfgDataW'(cnt);
    tracker.event_count = trwp_pkg::CountW'(cnt);
    @(negedge clk_i);
    cfg_index_i <= trwp_pkg::CfgTickIncrement;
    cfg_data_i  <= trwp_pkg::CfgDataW'(inc);
    tracker.tick_incr = trwp_pkg::IncrW'(inc);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Well-formed list: ticks never decrease, some events share a tick.
  task automatic play_list();
    int unsigned n;
    int unsigned t;
    int unsigned inc;
    n   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 16);
    inc = pick_incr();
    t   = 0;
    set_cfg(0, inc);
    send_tick();  // empty list rewinds pointer and tick index
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(make_load($urandom_range(n, Depth - 1), $urandom_range(0, 16'hFFFF),
                            $urandom_range(0, 255), $urandom_range(0, 255)));
      send_item(make_load(i, t, $urandom_range(0, 255), $urandom_range(0, 255)));
      if ($urandom_range(0, 2) != 0) t += $urandom_range(1, 2);
    end
    set_cfg(n, inc);
    repeat (t + 1 + $urandom_range(0, 4)) send_tick();
  endtask

  task automatic noise_burst();
    int unsigned cnt;
    case ($urandom_range(0, 4))
      0: cnt = 0;
      1: cnt = Depth;
      2: cnt = CountMax;
      default: cnt = $urandom_range(1, 40);
    endcase
    set_cfg(cnt, pick_incr());
    repeat ($urandom_range(4, 20)) begin
      if ($urandom_range(0, 1) == 0)
        send_item(make_load(
          ($urandom_range(0, 3) == 0) ? $urandom_range(0, Depth - 1) : $urandom_range(0, 47),
          ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 16'hFFFF),
          $urandom_range(0, 255), $urandom_range(0, 255)));
      else
        send_tick();
    end
  endtask

  initial begin
    int unsigned random_start;
    int unsigned phase;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list: status beat only, accumulator at full increment
    set_cfg(0, 16'hFFFF);
    send_tick();
    send_item(make_load(0, 0, 8'hFF, 8'h00));
    send_item(make_load(1, 0, 8'h00, 8'hFF));
    send_item(make_load(2, 2, 8'hA5, 8'h5A));
    send_item(make_load(3, 16'hFFFF, 8'h5A, 8'hA5));
    send_item(make_load(4, 16'hFFFF, 8'h3C, 8'hC3));
    send_item(make_load(Depth - 1, 16'hFFFF, 8'hFF, 8'hFF));
    send_tick();
    // count above depth acts as depth; entry 3 holds the pointer
    set_cfg(CountMax, 16'h8000);
    repeat (5) send_tick();
    // count lowered below the pointer: nothing due, list restarts
    set_cfg(2, 16'hFFFF);
    repeat (2) send_tick();
    set_cfg(Depth, 0);
    repeat (3) send_tick();

    // per-tick write limit: exactly at it, one past it, several past it
    set_cfg(0, 16'h1234);
    send_tick();
    for (int i = 0; i < 70; i++)
      send_item(make_load(i, 0, $urandom_range(0, 255), $urandom_range(0, 255)));
    set_cfg(MaxWrites, 16'h1234);
    send_tick();
    set_cfg(MaxWrites + 1, 16'h1234);
    send_tick();
    set_cfg(70, 16'hF00D);
    repeat (2) send_tick();

    random_start = items_sent;
    phase = 0;
    while (items_sent < random_start + RandomItems) begin
      set_idling(phase % 4);
      phase++;
      if ($urandom_range(0, 9) < 7) play_list();
      else noise_burst();
    end

    wait_idle();
    repeat (DrainCycles) @(negedge clk_i);
    if (tracker.due_beats.size() != 0)
      tracker.report($sformatf("%0d beats never arrived", tracker.due_beats.size()));
    if (tracker.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== timed_register_write_player_top.f =====
design/trwp_pkg.sv
design/trwp_mem.sv
design/trwp_ctrl.sv
design/timed_register_write_player_top.sv
bench/tb_timed_register_write_player_top.sv
